@@ hw/rtl/trd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants for the TGA RLE stream decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int unsigned SIG_LEN    = 12;
    localparam int unsigned HDR_LEN    = 18;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] TYPE_RAW  = 8'd2;
    localparam logic [7:0] TYPE_RLE  = 8'd10;
    localparam logic [7:0] BPP_24    = 8'd24;
    localparam logic [7:0] BPP_32    = 8'd32;
    localparam logic [7:0] RLE_SPLIT = 8'd128;
    localparam logic [7:0] RLE_BIAS  = 8'd127;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIG  = 2'd1;
    localparam logic [1:0] ST_BAD_ATTR = 2'd2;
    localparam logic [1:0] ST_CLIPPED  = 2'd3;

    typedef enum logic [1:0] {
        K_PIXEL,
        K_BAD_SIG,
        K_BAD_ATTR
    } t_kind;

    // One decoded entry handed from the parser to the output side
    typedef struct packed {
        t_kind       kind;
        logic [31:0] pixel;
        logic [7:0]  run;
        logic        alpha;
        logic        clip;
        logic        last;
    } t_cmd;

endpackage

@@ hw/rtl/trd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_byte_if / trd_pix_if
// Valid/ready channels: file bytes in, pixel runs out.
// ----------------------------------------------------------------------------
interface trd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface trd_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        has_alpha;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output pixel_value, output run_length,
                    output has_alpha, output status, output last, input ready);
    modport sink   (input valid, input pixel_value, input run_length,
                    input has_alpha, input status, input last, output ready);
endinterface

@@ hw/rtl/trd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_parser
// Front end: header check, pixel assembly, RLE packet and image accounting.
// ----------------------------------------------------------------------------
module trd_parser
    import trd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_RAW,
        PH_RLE_HDR,
        PH_RLE_PIX,
        PH_IDLE
    } t_phase;

    t_phase      r_phase, n_phase, w_phase;
    logic [4:0]  r_cnt, n_cnt, w_cnt;
    logic        r_raw_ok, n_raw_ok, w_raw_ok;
    logic        r_rle_ok, n_rle_ok, w_rle_ok;
    logic [15:0] r_w, n_w;
    logic [15:0] r_h, n_h;
    logic        r_is32, n_is32;
    logic        r_bpp_ok, n_bpp_ok;
    logic [31:0] r_pl, n_pl;
    logic [7:0]  r_pkt, n_pkt;
    logic        r_rep, n_rep;
    logic [1:0]  r_bip, n_bip;
    logic [31:0] r_accum, n_accum;

    logic        w_acc;
    logic        w_done;
    logic [31:0] w_pix;
    logic [31:0] w_area;
    logic [7:0]  w_run;
    logic [7:0]  w_want_raw, w_want_rle;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;

    // frame_start restarts the header before the byte is used
    assign w_phase  = i_frame_start ? PH_HEADER : r_phase;
    assign w_cnt    = i_frame_start ? 5'd0 : r_cnt;
    assign w_raw_ok = i_frame_start ? 1'b1 : r_raw_ok;
    assign w_rle_ok = i_frame_start ? 1'b1 : r_rle_ok;

    assign w_area     = {16'b0, r_w} * {16'b0, r_h};
    assign w_done     = (r_bip == (r_is32 ? 2'd3 : 2'd2));
    assign w_want_raw = (w_cnt == 5'd2) ? TYPE_RAW : 8'd0;
    assign w_want_rle = (w_cnt == 5'd2) ? TYPE_RLE : 8'd0;

    always_comb begin
        w_pix = r_accum;
        w_pix[8*r_bip +: 8] = i_data_byte;
    end

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_raw_ok = r_raw_ok;
        n_rle_ok = r_rle_ok;
        n_w      = r_w;
        n_h      = r_h;
        n_is32   = r_is32;
        n_bpp_ok = r_bpp_ok;
        n_pl     = r_pl;
        n_pkt    = r_pkt;
        n_rep    = r_rep;
        n_bip    = r_bip;
        n_accum  = r_accum;
        w_run    = 8'd1;
        o_push   = 1'b0;
        o_cmd    = '{kind: K_PIXEL, pixel: w_pix, run: 8'd1, alpha: r_is32,
                     clip: 1'b0, last: 1'b0};

        if (w_acc) begin
            if (i_frame_start) begin
                n_phase  = PH_HEADER;
                n_cnt    = 5'd0;
                n_raw_ok = 1'b1;
                n_rle_ok = 1'b1;
                n_is32   = 1'b0;
                n_bpp_ok = 1'b0;
                n_bip    = 2'd0;
            end
            unique case (w_phase)
                PH_HEADER: begin
                    if (w_cnt < 5'(SIG_LEN)) begin
                        n_raw_ok = w_raw_ok && (i_data_byte == w_want_raw);
                        n_rle_ok = w_rle_ok && (i_data_byte == w_want_rle);
                    end
                    unique case (w_cnt)
                        5'd12:   n_w[7:0]  = i_data_byte;
                        5'd13:   n_w[15:8] = i_data_byte;
                        5'd14:   n_h[7:0]  = i_data_byte;
                        5'd15:   n_h[15:8] = i_data_byte;
                        5'd16: begin
                            n_bpp_ok = (i_data_byte == BPP_24) || (i_data_byte == BPP_32);
                            n_is32   = (i_data_byte == BPP_32);
                        end
                        default: ;
                    endcase
                    if (w_cnt != 5'(HDR_LEN - 1)) begin
                        n_cnt = w_cnt + 5'd1;
                    end else if (r_w == 16'd0 || r_h == 16'd0 || !r_bpp_ok) begin
                        n_phase    = PH_IDLE;
                        o_push     = 1'b1;
                        o_cmd.kind = K_BAD_ATTR;
                        o_cmd.last = 1'b1;
                    end else if (!w_raw_ok && !w_rle_ok) begin
                        n_phase    = PH_IDLE;
                        o_push     = 1'b1;
                        o_cmd.kind = K_BAD_SIG;
                        o_cmd.last = 1'b1;
                    end else begin
                        n_pl    = w_area;
                        n_bip   = 2'd0;
                        n_accum = '0;
                        n_phase = w_raw_ok ? PH_RAW : PH_RLE_HDR;
                    end
                end
                PH_RAW: begin
                    if (w_done) begin
                        n_bip      = 2'd0;
                        n_accum    = '0;
                        n_pl       = r_pl - 32'd1;
                        o_push     = 1'b1;
                        o_cmd.last = (n_pl == 32'd0);
                        if (n_pl == 32'd0) n_phase = PH_IDLE;
                    end else begin
                        n_bip   = r_bip + 2'd1;
                        n_accum = w_pix;
                    end
                end
                PH_RLE_HDR: begin
                    if (i_data_byte < RLE_SPLIT) begin
                        n_pkt = i_data_byte + 8'd1;
                        n_rep = 1'b0;
                    end else begin
                        n_pkt = i_data_byte - RLE_BIAS;
                        n_rep = 1'b1;
                    end
                    n_bip   = 2'd0;
                    n_accum = '0;
                    n_phase = PH_RLE_PIX;
                end
                PH_RLE_PIX: begin
                    if (w_done) begin
                        n_bip   = 2'd0;
                        n_accum = '0;
                        if (r_rep) begin
                            // repeat run longer than what is left is cut short
                            if ({24'b0, r_pkt} > r_pl) begin
                                w_run      = r_pl[7:0];
                                o_cmd.clip = 1'b1;
                            end else begin
                                w_run = r_pkt;
                            end
                            n_pkt = 8'd0;
                        end else begin
                            w_run = 8'd1;
                            n_pkt = r_pkt - 8'd1;
                        end
                        n_pl       = r_pl - {24'b0, w_run};
                        o_push     = 1'b1;
                        o_cmd.run  = w_run;
                        o_cmd.last = (n_pl == 32'd0);
                        if (n_pl == 32'd0 && n_pkt != 8'd0) o_cmd.clip = 1'b1;
                        if (n_pl == 32'd0)     n_phase = PH_IDLE;
                        else if (n_pkt == 8'd0) n_phase = PH_RLE_HDR;
                    end else begin
                        n_bip   = r_bip + 2'd1;
                        n_accum = w_pix;
                    end
                end
                PH_IDLE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_cnt    <= 5'd0;
            r_raw_ok <= 1'b1;
            r_rle_ok <= 1'b1;
            r_w      <= 16'd0;
            r_h      <= 16'd0;
            r_is32   <= 1'b0;
            r_bpp_ok <= 1'b0;
            r_pl     <= 32'd0;
            r_pkt    <= 8'd0;
            r_rep    <= 1'b0;
            r_bip    <= 2'd0;
            r_accum  <= 32'd0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_raw_ok <= n_raw_ok;
            r_rle_ok <= n_rle_ok;
            r_w      <= n_w;
            r_h      <= n_h;
            r_is32   <= n_is32;
            r_bpp_ok <= n_bpp_ok;
            r_pl     <= n_pl;
            r_pkt    <= n_pkt;
            r_rep    <= n_rep;
            r_bip    <= n_bip;
            r_accum  <= n_accum;
        end
    end

endmodule

@@ hw/rtl/trd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_fifo
// Short queue of decoded entries between parser and output stage.
// ----------------------------------------------------------------------------
module trd_fifo
    import trd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + FIFO_AW'(1);
            if (w_pop)  r_rd <= r_rd + FIFO_AW'(1);
            if (w_push && !w_pop)      r_count <= r_count + (FIFO_AW+1)'(1);
            else if (w_pop && !w_push) r_count <= r_count - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

@@ hw/rtl/trd_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_emit
// Back end: formats queued entries into results and holds the output register.
// ----------------------------------------------------------------------------
module trd_emit
    import trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pixel_value,
    output logic [7:0]  o_run_length,
    output logic        o_has_alpha,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic        r_valid;
    logic [31:0] r_pix, n_pix;
    logic [7:0]  r_run, n_run;
    logic        r_alpha, n_alpha;
    logic [1:0]  r_status, n_status;
    logic        r_last;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        n_pix    = i_cmd.pixel;
        n_run    = i_cmd.run;
        n_alpha  = i_cmd.alpha;
        n_status = i_cmd.clip ? ST_CLIPPED : ST_OK;
        unique case (i_cmd.kind)
            K_PIXEL: ;
            K_BAD_SIG: begin
                n_pix    = '0;
                n_run    = '0;
                n_alpha  = 1'b0;
                n_status = ST_BAD_SIG;
            end
            K_BAD_ATTR: begin
                n_pix    = '0;
                n_run    = '0;
                n_alpha  = 1'b0;
                n_status = ST_BAD_ATTR;
            end
            default: begin
                n_pix    = '0;
                n_run    = '0;
                n_alpha  = 1'b0;
                n_status = ST_BAD_ATTR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_pix    <= n_pix;
            r_run    <= n_run;
            r_alpha  <= n_alpha;
            r_status <= n_status;
            r_last   <= i_cmd.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_value = r_pix;
    assign o_run_length  = r_run;
    assign o_has_alpha   = r_alpha;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

@@ hw/rtl/tga_rle_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_stream_decoder
// TGA (type 2 / type 10, 24 or 32 bpp) byte stream to pixel runs.
//
//   channel   dir  payload                                          transfer
//   i_byte    in   data_byte[7:0], frame_start                      valid & ready
//   o_res     out  pixel_value[31:0], run_length[7:0], has_alpha,   valid & ready
//                  status[1:0], last
//
// One byte per cycle while the queue has room; the parser updates all decode state in the same cycle.
// A completing byte's entry is written to the queue, then loaded into the output register as a result.
// i_byte.ready drops only when the four-entry queue is full.
// Synchronous active-low reset; no clearing pass, ready from the first cycle after reset.
// ----------------------------------------------------------------------------
module tga_rle_stream_decoder
    import trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    trd_byte_if.sink    i_byte,
    trd_pix_if.source   o_res
);

    t_cmd w_push_cmd, w_pop_cmd;
    logic w_push, w_full, w_pop, w_empty;

    trd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_byte.valid),
        .i_data_byte   (i_byte.data_byte),
        .i_frame_start (i_byte.frame_start),
        .o_ready       (i_byte.ready),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    trd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_empty (w_empty)
    );

    trd_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_pop_cmd),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_pixel_value (o_res.pixel_value),
        .o_run_length  (o_res.run_length),
        .o_has_alpha   (o_res.has_alpha),
        .o_status      (o_res.status),
        .o_last        (o_res.last)
    );

`ifndef SYNTHESIS
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.status == ST_BAD_SIG || o_res.status == ST_BAD_ATTR)
        |-> o_res.last && o_res.run_length == 8'd0 && o_res.pixel_value == 32'd0)
        else $error("error result not final or not zeroed");

    a_clip_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == ST_CLIPPED |-> o_res.last)
        else $error("clipped run not flagged last");

    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == ST_OK
        |-> o_res.run_length != 8'd0 && o_res.run_length <= RLE_SPLIT)
        else $error("run length out of range");

    a_no_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.has_alpha |-> o_res.pixel_value[31:24] == 8'd0)
        else $error("alpha byte set on 24 bpp pixel");
`endif

endmodule

@@ sim/tga_run_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_run_checker
// Watches the byte and pixel-run channels of the TGA decoder, decodes every
// accepted byte with its own header/packet parser, and compares each pixel
// run transfer field by field with the oldest run still owed.
// ----------------------------------------------------------------------------
module tga_run_checker
    import trd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    trd_byte_if  i_byte,
    trd_pix_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    // header byte offsets
    localparam int unsigned OFS_TYPE  = 2;
    localparam int unsigned OFS_W_LO  = 12;
    localparam int unsigned OFS_W_HI  = 13;
    localparam int unsigned OFS_H_LO  = 14;
    localparam int unsigned OFS_H_HI  = 15;
    localparam int unsigned OFS_BPP   = 16;

    typedef enum logic [2:0] {
        DEC_HEADER,
        DEC_RAW,
        DEC_PKT_HDR,
        DEC_PKT_PIX,
        DEC_DONE
    } t_dec_phase;

    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  run;
        logic        alpha;
        logic [1:0]  status;
        logic        last;
    } t_pix_run;

    t_pix_run    pending_runs[$];

    t_dec_phase  dec_phase;
    logic [4:0]  hdr_idx;
    logic        raw_sig_match;
    logic        rle_sig_match;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        alpha_mode;
    logic        bpp_valid;
    logic [31:0] pix_remaining;
    logic [7:0]  pkt_remaining;
    logic        pkt_is_repeat;
    logic [1:0]  byte_slot;
    logic [31:0] pix_acc;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic restart_parse();
        dec_phase     = DEC_HEADER;
        hdr_idx       = '0;
        raw_sig_match = 1'b1;
        rle_sig_match = 1'b1;
        img_w         = '0;
        img_h         = '0;
        alpha_mode    = 1'b0;
        bpp_valid     = 1'b0;
        pix_remaining = '0;
        pkt_remaining = '0;
        pkt_is_repeat = 1'b0;
        byte_slot     = '0;
        pix_acc       = '0;
    endtask

    task automatic expect_run(input logic [31:0] pixel, input logic [7:0] run,
                              input logic alpha, input logic [1:0] status,
                              input logic last);
        pending_runs.push_back('{pixel, run, alpha, status, last});
    endtask

    // true once the pixel under assembly is whole; 4 bytes wrap the slot to 0
    function automatic bit take_byte(input logic [7:0] b);
        logic [1:0] need;
        need = alpha_mode ? 2'd0 : 2'd3;
        pix_acc   = pix_acc | (32'(b) << (8 * byte_slot));
        byte_slot = byte_slot + 2'd1;
        if (byte_slot == need) begin
            byte_slot = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic fs);
        logic [31:0] px;
        logic [7:0]  run;
        logic [1:0]  st;
        logic        fin;
        if (fs) restart_parse();
        case (dec_phase)
            DEC_HEADER: begin
                if (hdr_idx < SIG_LEN) begin
                    if (b != ((hdr_idx == OFS_TYPE) ? TYPE_RAW : 8'h00)) raw_sig_match = 1'b0;
                    if (b != ((hdr_idx == OFS_TYPE) ? TYPE_RLE : 8'h00)) rle_sig_match = 1'b0;
                end else begin
                    case (hdr_idx)
                        OFS_W_LO: img_w[7:0]  = b;
                        OFS_W_HI: img_w[15:8] = b;
                        OFS_H_LO: img_h[7:0]  = b;
                        OFS_H_HI: img_h[15:8] = b;
                        OFS_BPP: begin
                            bpp_valid  = (b == BPP_24) || (b == BPP_32);
                            alpha_mode = (b == BPP_32);
                        end
                        default: ;
                    endcase
                end
                if (hdr_idx + 1 < HDR_LEN) begin
                    hdr_idx = hdr_idx + 5'd1;
                end else if (img_w == 0 || img_h == 0 || !bpp_valid) begin
                    // attributes win over a signature mismatch
                    dec_phase = DEC_DONE;
                    expect_run('0, '0, 1'b0, ST_BAD_ATTR, 1'b1);
                end else if (!raw_sig_match && !rle_sig_match) begin
                    dec_phase = DEC_DONE;
                    expect_run('0, '0, 1'b0, ST_BAD_SIG, 1'b1);
                end else begin
                    pix_remaining = 32'(img_w) * 32'(img_h);
                    byte_slot     = '0;
                    pix_acc       = '0;
                    dec_phase     = raw_sig_match ? DEC_RAW : DEC_PKT_HDR;
                end
            end
            DEC_RAW: begin
                if (take_byte(b)) begin
                    px            = pix_acc;
                    pix_acc       = '0;
                    pix_remaining = pix_remaining - 32'd1;
                    fin           = (pix_remaining == 0);
                    if (fin) dec_phase = DEC_DONE;
                    expect_run(px, 8'd1, alpha_mode, ST_OK, fin);
                end
            end
            DEC_PKT_HDR: begin
                if (b < RLE_SPLIT) begin
                    pkt_remaining = b + 8'd1;
                    pkt_is_repeat = 1'b0;
                end else begin
                    pkt_remaining = b - RLE_BIAS;
                    pkt_is_repeat = 1'b1;
                end
                byte_slot = '0;
                pix_acc   = '0;
                dec_phase = DEC_PKT_PIX;
            end
            DEC_PKT_PIX: begin
                if (take_byte(b)) begin
                    px      = pix_acc;
                    pix_acc = '0;
                    st      = ST_OK;
                    if (pkt_is_repeat) begin
                        run = pkt_remaining;
                        if (32'(run) > pix_remaining) begin
                            run = pix_remaining[7:0];
                            st  = ST_CLIPPED;
                        end
                        pkt_remaining = '0;
                    end else begin
                        run           = 8'd1;
                        pkt_remaining = pkt_remaining - 8'd1;
                    end
                    pix_remaining = pix_remaining - 32'(run);
                    fin = (pix_remaining == 0);
                    // raw packet still holding pixels when the image fills up
                    if (fin && pkt_remaining != 0) st = ST_CLIPPED;
                    if (fin) dec_phase = DEC_DONE;
                    else if (pkt_remaining == 0) dec_phase = DEC_PKT_HDR;
                    expect_run(px, run, alpha_mode, st, fin);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_pix_run want;
        if (!i_rst_n) begin
            restart_parse();
            pending_runs.delete();
            o_fail_count = 0;
        end else begin
            if (i_byte.valid && i_byte.ready)
                decode_byte(i_byte.data_byte, i_byte.frame_start);
            if (i_res.valid && i_res.ready) begin
                if (pending_runs.size() == 0) begin
                    report_mismatch($sformatf("run transfer with nothing owed, pixel %h",
                                              i_res.pixel_value));
                end else begin
                    want = pending_runs.pop_front();
                    if (i_res.pixel_value !== want.pixel)
                        report_mismatch($sformatf("pixel_value %h, wanted %h",
                                                  i_res.pixel_value, want.pixel));
                    if (i_res.run_length !== want.run)
                        report_mismatch($sformatf("run_length %0d, wanted %0d",
                                                  i_res.run_length, want.run));
                    if (i_res.has_alpha !== want.alpha)
                        report_mismatch($sformatf("has_alpha %b, wanted %b",
                                                  i_res.has_alpha, want.alpha));
                    if (i_res.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  i_res.status, want.status));
                    if (i_res.last !== want.last)
                        report_mismatch($sformatf("last %b, wanted %b",
                                                  i_res.last, want.last));
                end
            end
        end
        o_pending = pending_runs.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the TGA decoder with whole files: a few hand-built ones for the
// corner cases, then random files, mostly well formed with random pixel
// data, plus broken signatures, bad attributes, cut-off files and noise.
// Both channels stall at random, except for files 40 to 59; the run checker reports the outcome.
// ----------------------------------------------------------------------------
module tb_top;
    import trd_pkg::*;

    localparam int unsigned TYPE_OFS    = 2;
    localparam int          ITEM_TARGET = 1250;
    localparam int          PIX_CAP     = 40;
    localparam int          CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   pending_count;
    bit   idle_en = 1'b1;

    logic [7:0] file_q[$];
    int         file_useful;
    int         useful_sent = 0;

    trd_byte_if byte_ch();
    trd_pix_if  res_ch();

    tga_rle_stream_decoder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .o_res   (res_ch)
    );

    tga_run_checker u_run_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte       (byte_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        res_ch.ready <= idle_en ? ($urandom_range(0, 99) >= 15) : 1'b1;

    task automatic put_header(input logic [7:0] img_type, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] bpp);
        file_q.delete();
        for (int i = 0; i < SIG_LEN; i++)
            file_q.push_back((i == TYPE_OFS) ? img_type : 8'h00);
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
        file_q.push_back(bpp);
        file_q.push_back(8'($urandom_range(0, 255)));   // descriptor, not decoded
    endtask

    // fill < 0 gives random bytes
    task automatic push_pixel(input bit wide, input int fill);
        repeat (wide ? 4 : 3)
            file_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    endtask

    task automatic send_file(input bit with_start);
        for (int i = 0; i < file_q.size(); i++) begin
            while (idle_en && $urandom_range(0, 99) < 15) begin
                byte_ch.valid <= 1'b0;
                @(negedge clk);
            end
            byte_ch.valid       <= 1'b1;
            byte_ch.data_byte   <= file_q[i];
            byte_ch.frame_start <= with_start && (i == 0);
            @(posedge clk);
            while (!byte_ch.ready) @(posedge clk);
            @(negedge clk);
        end
        useful_sent += file_useful;
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
    endtask

    initial begin : stim
        int          roll;
        int          file_idx;
        int          left;
        int          cnt;
        int          cut;
        bit          wide;
        bit          use_rle;
        bit          rep;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  bpp;
        longint      area;

        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'h00;
        byte_ch.frame_start = 1'b0;
        res_ch.ready        = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // raw 24 bpp straight out of reset, no frame start; extreme pixels, one stray byte
        put_header(TYPE_RAW, 16'd1, 16'd2, BPP_24);
        push_pixel(1'b0, 255);
        push_pixel(1'b0, 0);
        file_q.push_back(8'hA5);
        file_useful = 24;
        send_file(1'b0);

        // longest repeat packet clipped to a 2-pixel image
        put_header(TYPE_RLE, 16'd2, 16'd1, BPP_32);
        file_q.push_back(8'hFF);
        push_pixel(1'b1, 255);
        file_useful = file_q.size();
        send_file(1'b1);

        // single-copy repeat, then longest raw packet overrunning the image end
        put_header(TYPE_RLE, 16'd4, 16'd1, BPP_24);
        file_q.push_back(8'h80);
        push_pixel(1'b0, -1);
        file_q.push_back(8'h7F);
        repeat (3) push_pixel(1'b0, -1);
        file_useful = file_q.size();
        send_file(1'b1);

        // zero width together with a broken type byte: attributes take precedence
        put_header(8'd3, 16'd0, 16'd1, BPP_24);
        file_useful = file_q.size();
        send_file(1'b1);

        // broken signature only
        put_header(TYPE_RAW, 16'd1, 16'd1, BPP_32);
        file_q[0] = 8'hFF;
        send_file(1'b1);

        // zero height, then an unsupported depth
        put_header(TYPE_RLE, 16'd5, 16'd0, BPP_32);
        send_file(1'b1);
        put_header(TYPE_RAW, 16'd1, 16'd1, 8'd16);
        send_file(1'b1);

        // largest image, abandoned mid-pixel by the next frame start
        put_header(TYPE_RLE, 16'hFFFF, 16'hFFFF, BPP_32);
        file_q.push_back(8'hFF);
        push_pixel(1'b1, 0);
        file_q.push_back(8'h00);
        file_q.push_back(8'h5A);
        file_q.push_back(8'hC3);
        file_useful = file_q.size();
        send_file(1'b1);

        // header cut short
        put_header(TYPE_RAW, 16'd1, 16'd1, BPP_24);
        while (file_q.size() > 7) void'(file_q.pop_back());
        file_useful = file_q.size();
        send_file(1'b1);

        drain_results();

        file_idx = 0;
        while (useful_sent < ITEM_TARGET) begin
            file_idx++;
            idle_en <= !(file_idx >= 40 && file_idx < 60);
            roll = $urandom_range(0, 99);
            wide = $urandom_range(0, 1);
            use_rle = $urandom_range(0, 1);
            w = 16'($urandom_range(1, 6));
            h = 16'($urandom_range(1, 4));
            bpp = wide ? BPP_32 : BPP_24;
            if (roll < 75) begin
                if ($urandom_range(0, 9) == 0) begin
                    w = 16'($urandom_range(1, 16'hFFFF));
                    h = 16'($urandom_range(1, 16'hFFFF));
                end
                put_header(use_rle ? TYPE_RLE : TYPE_RAW, w, h, bpp);
                area = longint'(w) * longint'(h);
                left = (area > PIX_CAP) ? PIX_CAP : int'(area);
                if (!use_rle) begin
                    repeat (left) push_pixel(wide, -1);
                end else begin
                    while (left > 0) begin
                        rep = $urandom_range(0, 1);
                        if ($urandom_range(0, 6) == 0)
                            cnt = $urandom_range(1, 128);
                        else
                            cnt = $urandom_range(1, (left < 8) ? left : 8);
                        // keep raw-packet overruns short
                        if (!rep && cnt > left) cnt = left + $urandom_range(1, 3);
                        file_q.push_back(rep ? 8'(RLE_BIAS + cnt) : 8'(cnt - 1));
                        if (rep) push_pixel(wide, -1);
                        else repeat (cnt) push_pixel(wide, -1);
                        left -= cnt;
                    end
                end
                if ($urandom_range(0, 11) == 0) begin
                    cut = $urandom_range(1, file_q.size() - 1);
                    while (file_q.size() > cut) void'(file_q.pop_back());
                end
                file_useful = file_q.size();
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom_range(0, 255)));
            end else if (roll < 95) begin
                if (roll >= 85) begin
                    case ($urandom_range(0, 2))
                        0:       w = '0;
                        1:       h = '0;
                        default: bpp = 8'($urandom_range(0, 255));
                    endcase
                end
                put_header(use_rle ? TYPE_RLE : TYPE_RAW, w, h, bpp);
                if (roll < 85 || $urandom_range(0, 1) == 1) begin
                    cut = $urandom_range(0, SIG_LEN - 1);
                    file_q[cut] = file_q[cut] ^ 8'($urandom_range(1, 255));
                end
                file_useful = file_q.size();
                repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                file_q.delete();
                repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom_range(0, 255)));
                file_useful = file_q.size();
            end
            send_file(1'b1);
            if ($urandom_range(0, 19) == 0) drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
